@@ src/adjacency_matrix_dfs_order_assert.svh @@
// Assertion macros shared by the depth-first search block.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef ADJACENCY_MATRIX_DFS_ORDER_ASSERT_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent and consequent in the same cycle.
`define AMDFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define AMDFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define AMDFS_ASSERT_SAME(label, clk, rst, ante, cons)
`define AMDFS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/amdfs_pkg.sv @@
// Shared constants and types of the depth-first search block.
// Used by the traversal stack and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package amdfs_pkg;

   // Default graph size.
   localparam int NUM_VERTICES_DEF = 8;

   // Fixed widths of the request and result fields.
   localparam int CMD_W       = 1;
   localparam int INDEX_W     = 3;
   localparam int ROW_BITS_W  = 8;
   localparam int VERTEX_W    = 3;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_START = 1'b1;

   // Control of the traversal stack.
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stk_ctrl_type;

endpackage

`default_nettype wire

@@ src/amdfs_stack.sv @@
// Stack of suspended vertices for the depth-first walk, each with its resume column.
// Depends on amdfs_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module amdfs_stack #(
   parameter int NUM_VERTICES = amdfs_pkg::NUM_VERTICES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire amdfs_pkg::stk_ctrl_type           ctrl,
   input  wire logic [$clog2(NUM_VERTICES)-1:0]   wr_vertex,
   input  wire logic [$clog2(NUM_VERTICES)-1:0]   wr_resume,
   output logic      [$clog2(NUM_VERTICES)-1:0]   rd_vertex,
   output logic      [$clog2(NUM_VERTICES)-1:0]   rd_resume,
   output logic                                   empty
);

   localparam int VW = $clog2(NUM_VERTICES);

   logic [2*VW-1:0] mem [NUM_VERTICES];
   logic [VW-1:0]   sp_ff;
   logic [VW-1:0]   sp_in;
   logic [VW-1:0]   rd_addr;
   logic [2*VW-1:0] rd_data_ff;

   always_comb begin
      sp_in = sp_ff;
      if (ctrl.clear) begin
         sp_in = '0;
      end else if (ctrl.push) begin
         sp_in = sp_ff + 1'b1;
      end else if (ctrl.pop) begin
         sp_in = sp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // The top entry is read every cycle; data shows in the cycle after the pointer moves.
   assign rd_addr = (sp_ff == '0) ? '0 : sp_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[sp_ff] <= {wr_vertex, wr_resume};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_vertex = rd_data_ff[2*VW-1:VW];
   assign rd_resume = rd_data_ff[VW-1:0];
   assign empty     = (sp_ff == '0);

endmodule

`default_nettype wire

@@ src/adjacency_matrix_dfs_order.sv @@
// Depth-first preorder walk over an adjacency bit matrix, top level.
// Depends on amdfs_pkg, amdfs_stack and adjacency_matrix_dfs_order_assert.svh.
//
//   Channel   Handshake          Payload
//   request   start / busy       req_cmd, req_row_index, req_row_bits, req_start_vertex
//   result    rsp_valid strobe   rsp_vertex, rsp_last
//
// A load request writes its row without raising busy. A start request keeps busy high
// while the walk runs: each vertex reached takes a row fetch and then a test of one
// column at a time, and each return to a parent takes a stack pop, a fresh row fetch
// and a second test of the finished child's column. The single bit test on the fetched
// row is the shared unit that tests every column. Reset is synchronous and clears the
// matrix valid bits, the visited marks and the sequencer. Results are one-cycle strobes;
// the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

`include "adjacency_matrix_dfs_order_assert.svh"

module adjacency_matrix_dfs_order #(
   parameter int NUM_VERTICES = amdfs_pkg::NUM_VERTICES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [amdfs_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [amdfs_pkg::INDEX_W-1:0]       req_row_index,
   input  wire logic [amdfs_pkg::ROW_BITS_W-1:0]    req_row_bits,
   input  wire logic [amdfs_pkg::INDEX_W-1:0]       req_start_vertex,
   output logic                                     rsp_valid,
   output logic      [amdfs_pkg::VERTEX_W-1:0]      rsp_vertex,
   output logic                                     rsp_last
);

   localparam int VW = $clog2(NUM_VERTICES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_POP
   } state_type;

   state_type                          state_ff, state_in;
   logic [NUM_VERTICES-1:0]            visited_ff, visited_in;
   logic [VW-1:0]                      cur_v_ff, cur_v_in;
   logic [VW-1:0]                      cur_j_ff, cur_j_in;
   logic [VW-1:0]                      pend_v_ff, pend_v_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [amdfs_pkg::VERTEX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;

   // Adjacency store: one row per vertex, with a valid bit so reset reads as all zero.
   logic [NUM_VERTICES-1:0]            adj_mem [NUM_VERTICES];
   logic [NUM_VERTICES-1:0]            row_valid_ff;
   logic [NUM_VERTICES-1:0]            row_ff;
   logic                               row_ok_ff;

   amdfs_pkg::stk_ctrl_type            stk_ctrl;
   logic [VW-1:0]                      stk_rd_vertex;
   logic [VW-1:0]                      stk_rd_resume;
   logic                               stk_empty;

   logic                               accept;
   logic                               load_ok;
   logic                               start_ok;
   logic [VW-1:0]                      load_idx;
   logic [VW-1:0]                      start_idx;
   logic                               hit;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign load_idx  = VW'(req_row_index);
   assign start_idx = VW'(req_start_vertex);
   assign load_ok   = accept && (req_cmd == amdfs_pkg::CMD_LOAD)
                      && (int'(req_row_index) < NUM_VERTICES);
   assign start_ok  = int'(req_start_vertex) < NUM_VERTICES;

   // A load writes the row with the bits beyond the graph dropped.
   always_ff @(posedge clock) begin
      if (load_ok) begin
         adj_mem[load_idx] <= NUM_VERTICES'(req_row_bits);
      end
      row_ff <= adj_mem[cur_v_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         row_ok_ff    <= 1'b0;
      end else begin
         if (load_ok) begin
            row_valid_ff[load_idx] <= 1'b1;
         end
         row_ok_ff <= row_valid_ff[cur_v_ff];
      end
   end

   // The shared unit: one column of the current row tested against the visited marks.
   assign hit = row_ok_ff && row_ff[cur_j_ff] && !visited_ff[cur_j_ff];

   amdfs_stack #(
      .NUM_VERTICES (NUM_VERTICES)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stk_ctrl),
      .wr_vertex (cur_v_ff),
      .wr_resume (cur_j_ff),
      .rd_vertex (stk_rd_vertex),
      .rd_resume (stk_rd_resume),
      .empty     (stk_empty)
   );

   // The most recent vertex is held back one step, because only the end of the walk
   // tells whether it is the last one.
   always_comb begin
      state_in      = state_ff;
      visited_in    = visited_ff;
      cur_v_in      = cur_v_ff;
      cur_j_in      = cur_j_ff;
      pend_v_in     = pend_v_ff;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      stk_ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == amdfs_pkg::CMD_START)) begin
               visited_in = '0;
               if (start_ok) begin
                  visited_in[start_idx] = 1'b1;
                  cur_v_in       = start_idx;
                  cur_j_in       = '0;
                  pend_v_in      = start_idx;
                  stk_ctrl.clear = 1'b1;
                  state_in       = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               // Descend: suspend the current vertex and resume it at this column later.
               visited_in[cur_j_ff] = 1'b1;
               stk_ctrl.push = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = amdfs_pkg::VERTEX_W'(pend_v_ff);
               pend_v_in     = cur_j_ff;
               cur_v_in      = cur_j_ff;
               cur_j_in      = '0;
               state_in      = ST_FETCH;
            end else if (cur_j_ff == VW'(NUM_VERTICES - 1)) begin
               if (stk_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_vertex_in = amdfs_pkg::VERTEX_W'(pend_v_ff);
                  state_in      = ST_IDLE;
               end else begin
                  stk_ctrl.pop = 1'b1;
                  state_in     = ST_POP;
               end
            end else begin
               cur_j_in = cur_j_ff + 1'b1;
            end
         end
         ST_POP: begin
            // The resume column holds the child just finished; it is visited, so the
            // rescan passes it without descending again.
            cur_v_in = stk_rd_vertex;
            cur_j_in = stk_rd_resume;
            state_in = ST_FETCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      cur_v_ff      <= cur_v_in;
      cur_j_ff      <= cur_j_in;
      pend_v_ff     <= pend_v_in;
      rsp_vertex_ff <= rsp_vertex_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

   // The final result of a walk arrives as the sequencer returns to idle.
   `AMDFS_ASSERT_SAME(a_last_ends_walk, clock, reset, rsp_valid && rsp_last, !busy)
   // Any earlier result arrives while the walk is still running.
   `AMDFS_ASSERT_SAME(a_inner_while_busy, clock, reset, rsp_valid && !rsp_last, busy)
   // The row being scanned always belongs to a vertex already reached.
   `AMDFS_ASSERT_SAME(a_scan_visited, clock, reset, state_ff == ST_SCAN, visited_ff[cur_v_ff])
   // A start on a vertex inside the graph always launches a walk.
   `AMDFS_ASSERT_NEXT(a_start_launches, clock, reset,
      accept && (req_cmd == amdfs_pkg::CMD_START) && start_ok, state_ff == ST_FETCH)

endmodule

`default_nettype wire
